// ===== hw/rtl/rvpf_pkg.sv =====
// Shared types and constants for the radial vignette pixel filter.
package rvpf_pkg;

   localparam int unsigned PixelWidth = 24;
   localparam int unsigned CountWidth = 12;
   localparam int unsigned DimWidth   = 13;
   localparam int unsigned InvWidth   = 17;
   localparam int unsigned StrWidth   = 19;
   localparam int unsigned MagWidth   = 19;
   localparam int unsigned RadWidth   = 40;
   localparam int unsigned RootWidth  = 20;
   localparam int unsigned WgtWidth   = 17;

   localparam logic [DimWidth-1:0]  MaxDim    = 13'd4096;
   localparam logic [16:0]          K142      = 17'd93061;
   localparam logic [28:0]          HalfFx    = 29'd32768;
   localparam logic [28:0]          OfsTop    = 29'd294912;
   localparam logic [MagWidth-1:0]  OfsLimit  = 19'd262144;
   localparam logic [WgtWidth-1:0]  OneFx     = 17'd65536;

   localparam logic [2:0] CSR_FRAME_WIDTH  = 3'd0;
   localparam logic [2:0] CSR_FRAME_HEIGHT = 3'd1;
   localparam logic [2:0] CSR_INV_WIDTH    = 3'd2;
   localparam logic [2:0] CSR_INV_HEIGHT   = 3'd3;
   localparam logic [2:0] CSR_STRENGTH     = 3'd4;

   typedef struct packed {
      logic [PixelWidth-1:0] pixel;
      logic [CountWidth-1:0] col;
      logic [CountWidth-1:0] row;
      logic                  frame_end;
   } item_type;

endpackage

// ===== hw/rtl/rvpf_front.sv =====
// Front end: accepts requests, tracks raster position, tags frame end.
module rvpf_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic [rvpf_pkg::PixelWidth-1:0] req_pixel_rgb,
   input  logic                           req_frame_start,
   input  logic [rvpf_pkg::DimWidth-1:0]  width,
   input  logic [rvpf_pkg::DimWidth-1:0]  height,
   output logic                           push,
   output rvpf_pkg::item_type             push_item
);

   logic [rvpf_pkg::CountWidth-1:0] col_ff, col_in, row_ff, row_in, col_base, row_base;
   logic [rvpf_pkg::DimWidth-1:0]   w_eff, h_eff;
   logic                            row_end, frm_end;

   always_comb begin
      w_eff = (width == '0) ? 13'd1 : (width > rvpf_pkg::MaxDim) ? rvpf_pkg::MaxDim : width;
      h_eff = (height == '0) ? 13'd1 : (height > rvpf_pkg::MaxDim) ? rvpf_pkg::MaxDim : height;
      col_base = req_frame_start ? '0 : col_ff;
      row_base = req_frame_start ? '0 : row_ff;
      row_end  = ({1'b0, col_base} + 13'd1) >= w_eff;
      frm_end  = row_end && (({1'b0, row_base} + 13'd1) >= h_eff);
      push = req_valid && !req_stall;
      push_item.pixel     = req_pixel_rgb;
      push_item.col       = col_base;
      push_item.row       = row_base;
      push_item.frame_end = frm_end;
      col_in = col_ff;
      row_in = row_ff;
      if (push) begin
         if (row_end) begin
            col_in = '0;
            row_in = frm_end ? '0 : row_base + 12'd1;
         end else begin
            col_in = col_base + 12'd1;
            row_in = row_base;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

// ===== hw/rtl/rvpf_queue.sv =====
// Short request queue between front and back ends.
module rvpf_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  rvpf_pkg::item_type push_item,
   input  logic               pop,
   output logic               full,
   output logic               not_empty,
   output rvpf_pkg::item_type head
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   rvpf_pkg::item_type slot_ff [DEPTH];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]   cnt_ff, cnt_in;

   function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
      bump = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
   endfunction

   always_comb begin
      full      = cnt_ff == (AW+1)'(DEPTH);
      not_empty = cnt_ff != '0;
      head      = slot_ff[rd_ff];
      wr_in     = push ? bump(wr_ff) : wr_ff;
      rd_in     = pop ? bump(rd_ff) : rd_ff;
      cnt_in    = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_item;
      end
   end

endmodule

// ===== hw/rtl/rvpf_back.sv =====
// Back end: offset, distance, weight and channel scaling with output register.
module rvpf_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               q_valid,
   input  rvpf_pkg::item_type                 q_head,
   output logic                               q_pop,
   input  logic [rvpf_pkg::InvWidth-1:0]      inv_w,
   input  logic [rvpf_pkg::InvWidth-1:0]      inv_h,
   input  logic signed [rvpf_pkg::StrWidth-1:0] strength,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [rvpf_pkg::PixelWidth-1:0]    rsp_pixel_rgb_out,
   output logic                               rsp_frame_end
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SQR   = 3'd1;
   localparam logic [2:0] ST_ROOT  = 3'd2;
   localparam logic [2:0] ST_SCALE = 3'd3;
   localparam logic [2:0] ST_MIX   = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   logic [2:0] st_ff, st_in;
   logic [4:0] cnt_ff, cnt_in;
   logic [28:0] px_ff, px_in, py_ff, py_in;
   logic [rvpf_pkg::PixelWidth-1:0] pix_ff, pix_in;
   logic fe_ff, fe_in;
   logic [rvpf_pkg::RadWidth-1:0]  rad_ff, rad_in;
   logic [21:0] rem_ff, rem_in, rem_sh, trial;
   logic [rvpf_pkg::RootWidth-1:0] root_ff, root_in;
   logic [36:0] dec_ff, dec_in;
   logic [rvpf_pkg::WgtWidth-1:0]  wt_ff, wt_in;
   logic [rvpf_pkg::MagWidth-1:0]  mx, my;
   logic signed [22:0] wsum;
   logic [24:0] cr, cg, cb;
   logic vld_ff, vld_in;
   logic [rvpf_pkg::PixelWidth-1:0] out_ff, out_in;
   logic fe_out_ff, fe_out_in;

   function automatic logic [rvpf_pkg::MagWidth-1:0] mag(input logic [28:0] p);
      if (p >= rvpf_pkg::OfsTop) begin
         mag = rvpf_pkg::OfsLimit;
      end else if (p >= rvpf_pkg::HalfFx) begin
         mag = rvpf_pkg::MagWidth'(p - rvpf_pkg::HalfFx);
      end else begin
         mag = rvpf_pkg::MagWidth'(rvpf_pkg::HalfFx - p);
      end
   endfunction

   always_comb begin
      st_in = st_ff; cnt_in = cnt_ff; px_in = px_ff; py_in = py_ff;
      pix_in = pix_ff; fe_in = fe_ff; rad_in = rad_ff; rem_in = rem_ff;
      root_in = root_ff; dec_in = dec_ff; wt_in = wt_ff;
      vld_in = vld_ff && rsp_stall; out_in = out_ff; fe_out_in = fe_out_ff;
      q_pop = 1'b0;
      mx = mag(px_ff);
      my = mag(py_ff);
      rem_sh = {rem_ff[19:0], rad_ff[39:38]};
      trial  = {root_ff, 2'b01};
      wsum = 23'sd65536 - $signed({2'b00, dec_ff[36:16]}) + 23'(strength);
      cr = pix_ff[23:16] * wt_ff;
      cg = pix_ff[15:8]  * wt_ff;
      cb = pix_ff[7:0]   * wt_ff;
      unique case (st_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               px_in  = q_head.col * inv_w;
               py_in  = q_head.row * inv_h;
               pix_in = q_head.pixel;
               fe_in  = q_head.frame_end;
               st_in  = ST_SQR;
            end
         end
         ST_SQR: begin
            rad_in  = 40'(38'(mx * mx) + 38'(my * my));
            rem_in  = '0;
            root_in = '0;
            cnt_in  = '0;
            st_in   = ST_ROOT;
         end
         ST_ROOT: begin
            rad_in = {rad_ff[37:0], 2'b00};
            if (rem_sh >= trial) begin
               rem_in  = rem_sh - trial;
               root_in = {root_ff[18:0], 1'b1};
            end else begin
               rem_in  = rem_sh;
               root_in = {root_ff[18:0], 1'b0};
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(rvpf_pkg::RootWidth - 1)) begin
               st_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            dec_in = root_ff * rvpf_pkg::K142;
            st_in  = ST_MIX;
         end
         ST_MIX: begin
            if (wsum < 0) begin
               wt_in = '0;
            end else if (wsum > 23'sd65536) begin
               wt_in = rvpf_pkg::OneFx;
            end else begin
               wt_in = wsum[16:0];
            end
            st_in = ST_DONE;
         end
         ST_DONE: begin
            if (!vld_ff || !rsp_stall) begin
               vld_in    = 1'b1;
               out_in    = {cr[23:16], cg[23:16], cb[23:16]};
               fe_out_in = fe_ff;
               st_in     = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
      rsp_valid         = vld_ff;
      rsp_pixel_rgb_out = out_ff;
      rsp_frame_end     = fe_out_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= ST_IDLE;
         vld_ff <= 1'b0;
      end else begin
         st_ff  <= st_in;
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in; px_ff <= px_in; py_ff <= py_in; pix_ff <= pix_in;
      fe_ff <= fe_in; rad_ff <= rad_in; rem_ff <= rem_in; root_ff <= root_in;
      dec_ff <= dec_in; wt_ff <= wt_in; out_ff <= out_in; fe_out_ff <= fe_out_in;
   end

endmodule

// ===== hw/rtl/radial_vignette_pixel_filter.sv =====
// Top level of the radial vignette pixel filter.
// Usage:
//   Request channel req_*: one packed RGB pixel per request in row-major order,
//   req_frame_start marks the first pixel of a frame. req_stall is high while
//   the internal queue is full.
//   Response channel rsp_*: one weighted pixel per request, in order, with
//   rsp_frame_end on the last pixel of the frame; rsp_stall holds the result.
//   CSR channel csr_*: register index and data, always ready; write only
//   while idle.
// Timing:
//   The back end takes one pixel at a time through its idle, square, root,
//   scale, mix and done states, with the single shared root unit producing
//   one result bit a cycle. It pops no new pixel until the last leaves done,
//   and done waits while rsp_stall holds an earlier result.
//   The queue keeps accepting up to QUEUE_DEPTH requests while a result waits.
// Reset:
//   Synchronous; clears the position counters, queue and output valid and
//   loads the registers with 640, 480, 102, 137 and 0.
module radial_vignette_pixel_filter #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [23:0] req_pixel_rgb,
   input  logic        req_frame_start,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [23:0] rsp_pixel_rgb_out,
   output logic        rsp_frame_end,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [18:0] csr_wdata
);

   logic [12:0] width_ff, height_ff;
   logic [16:0] inv_w_ff, inv_h_ff;
   logic signed [18:0] str_ff;
   logic push, pop, full, not_empty;
   rvpf_pkg::item_type push_item, head;

   assign csr_ready = 1'b1;
   assign req_stall = full;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 13'd640;
         height_ff <= 13'd480;
         inv_w_ff  <= 17'd102;
         inv_h_ff  <= 17'd137;
         str_ff    <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            rvpf_pkg::CSR_FRAME_WIDTH:  width_ff  <= csr_wdata[12:0];
            rvpf_pkg::CSR_FRAME_HEIGHT: height_ff <= csr_wdata[12:0];
            rvpf_pkg::CSR_INV_WIDTH:    inv_w_ff  <= csr_wdata[16:0];
            rvpf_pkg::CSR_INV_HEIGHT:   inv_h_ff  <= csr_wdata[16:0];
            rvpf_pkg::CSR_STRENGTH:     str_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   rvpf_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_pixel_rgb, .req_frame_start,
      .width(width_ff), .height(height_ff), .push, .push_item
   );

   rvpf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock, .reset, .push, .push_item, .pop, .full, .not_empty, .head
   );

   rvpf_back u_back (
      .clock, .reset, .q_valid(not_empty), .q_head(head), .q_pop(pop),
      .inv_w(inv_w_ff), .inv_h(inv_h_ff), .strength(str_ff),
      .rsp_valid, .rsp_stall, .rsp_pixel_rgb_out, .rsp_frame_end
   );

endmodule

// ===== verif/rvpf_checker.sv =====
// Scoreboard for the radial vignette pixel filter: predicts each weighted pixel and compares it.
`timescale 1ns / 1ps
module rvpf_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [23:0] req_pixel_rgb,
   input  logic        req_frame_start,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [23:0] rsp_pixel_rgb_out,
   input  logic        rsp_frame_end,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [18:0] csr_wdata,
   output int          fail_count,
   output int          pending,
   output int          frames_done
);

   typedef struct packed {
      logic [23:0] rgb;
      logic        last;
   } shaded_pixel_type;

   logic [12:0] width_q, height_q;
   logic [16:0] inv_w_q, inv_h_q;
   logic [18:0] strength_q;
   logic [11:0] col_q, row_q;
   shaded_pixel_type shaded_q[$];

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v   = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic longint axis_offset(logic [11:0] pos, logic [16:0] inv);
      longint o;
      o = longint'(pos) * longint'(inv) - 32768;
      if (o > 262144) o = 262144;
      if (o < -262144) o = -262144;
      return o;
   endfunction

   function automatic longint clamp_dim(logic [12:0] d);
      if (d == 0) return 1;
      if (d > 4096) return 4096;
      return longint'(d);
   endfunction

   // advance the position counters and return the expected pixel
   function automatic shaded_pixel_type shade_pixel(logic [23:0] pix, logic fs);
      shaded_pixel_type p;
      longint ox, oy, wt, w, h;
      longint unsigned t;
      logic row_end, frm_end;
      w = clamp_dim(width_q);
      h = clamp_dim(height_q);
      if (fs) begin
         col_q = '0;
         row_q = '0;
      end
      ox = axis_offset(col_q, inv_w_q);
      oy = axis_offset(row_q, inv_h_q);
      t  = int_sqrt(longint'(ox * ox + oy * oy));
      wt = 65536 - ((longint'(t) * 93061) >>> 16) + longint'($signed(strength_q));
      if (wt < 0) wt = 0;
      if (wt > 65536) wt = 65536;
      p.rgb[23:16] = 8'((longint'(pix[23:16]) * wt) >> 16);
      p.rgb[15:8]  = 8'((longint'(pix[15:8]) * wt) >> 16);
      p.rgb[7:0]   = 8'((longint'(pix[7:0]) * wt) >> 16);
      row_end = (longint'(col_q) + 1 >= w);
      frm_end = row_end && (longint'(row_q) + 1 >= h);
      p.last  = frm_end;
      if (row_end) begin
         col_q = '0;
         row_q = frm_end ? 12'd0 : row_q + 12'd1;
      end else begin
         col_q = col_q + 12'd1;
      end
      return p;
   endfunction

   always @(posedge clock) begin
      shaded_pixel_type want;
      int errs;
      errs = 0;
      if (reset) begin
         width_q    <= 13'd640;
         height_q   <= 13'd480;
         inv_w_q    <= 17'd102;
         inv_h_q    <= 17'd137;
         strength_q <= '0;
         col_q = '0;
         row_q = '0;
         shaded_q.delete();
         fail_count  <= 0;
         frames_done <= 0;
         pending     <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               rvpf_pkg::CSR_FRAME_WIDTH: width_q <= csr_wdata[12:0];
               rvpf_pkg::CSR_FRAME_HEIGHT: height_q <= csr_wdata[12:0];
               rvpf_pkg::CSR_INV_WIDTH: inv_w_q <= csr_wdata[16:0];
               rvpf_pkg::CSR_INV_HEIGHT: inv_h_q <= csr_wdata[16:0];
               rvpf_pkg::CSR_STRENGTH: strength_q <= csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            shaded_q.push_back(shade_pixel(req_pixel_rgb, req_frame_start));
         if (rsp_valid && !rsp_stall) begin
            if (shaded_q.size() == 0) begin
               $error("unexpected response: pixel_rgb_out %h frame_end %b",
                  rsp_pixel_rgb_out, rsp_frame_end);
               errs++;
            end else begin
               want = shaded_q.pop_front();
               if (rsp_frame_end) frames_done <= frames_done + 1;
               if (rsp_pixel_rgb_out !== want.rgb) begin
                  $error("pixel_rgb_out mismatch: expected %h actual %h",
                     want.rgb, rsp_pixel_rgb_out);
                  errs++;
               end
               if (rsp_frame_end !== want.last) begin
                  $error("frame_end mismatch: expected %b actual %b",
                     want.last, rsp_frame_end);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
         pending    <= shaded_q.size();
      end
   end

endmodule

// ===== verif/tb_radial_vignette_pixel_filter.sv =====
// Testbench top for the radial vignette pixel filter: stimulus, register setup and verdict.
`timescale 1ns / 1ps
module tb_radial_vignette_pixel_filter;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [23:0] req_pixel_rgb = '0;
   logic        req_frame_start = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [23:0] rsp_pixel_rgb_out;
   logic        rsp_frame_end;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [18:0] csr_wdata = '0;

   int fail_count, pending, frames_done;
   int pixels_sent = 0;
   int send_gap_max = 15;
   int drain_gap_max = 15;
   int drain_left = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   radial_vignette_pixel_filter u_top (
      .clock, .reset,
      .req_valid, .req_stall, .req_pixel_rgb, .req_frame_start,
      .rsp_valid, .rsp_stall, .rsp_pixel_rgb_out, .rsp_frame_end,
      .csr_valid, .csr_ready, .csr_index, .csr_wdata
   );

   rvpf_checker u_checker (
      .clock, .reset,
      .req_valid, .req_stall, .req_pixel_rgb, .req_frame_start,
      .rsp_valid, .rsp_stall, .rsp_pixel_rgb_out, .rsp_frame_end,
      .csr_valid, .csr_ready, .csr_index, .csr_wdata,
      .fail_count, .pending, .frames_done
   );

   // hold off responses for a random count after each one
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         drain_left <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         drain_left <= $urandom_range(0, drain_gap_max);
         rsp_stall  <= ($urandom_range(0, drain_gap_max) != 0) && (drain_gap_max != 0);
      end else if (drain_left > 0) begin
         drain_left <= drain_left - 1;
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic send_pixel(logic [23:0] pix, logic fs);
      int gap;
      gap = $urandom_range(0, send_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_pixel_rgb   <= pix;
      req_frame_start <= fs;
      do @(posedge clock); while (req_stall);
      pixels_sent++;
   endtask

   task automatic drain_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_csr(logic [2:0] idx, logic [18:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic setup_frame(logic [12:0] w, logic [12:0] h, logic [16:0] iw,
                              logic [16:0] ih, logic [18:0] s);
      drain_idle();
      write_csr(rvpf_pkg::CSR_FRAME_WIDTH, 19'(w));
      write_csr(rvpf_pkg::CSR_FRAME_HEIGHT, 19'(h));
      write_csr(rvpf_pkg::CSR_INV_WIDTH, 19'(iw));
      write_csr(rvpf_pkg::CSR_INV_HEIGHT, 19'(ih));
      write_csr(rvpf_pkg::CSR_STRENGTH, s);
   endtask

   initial begin
      int w, h, n, k, phase;
      logic [16:0] iw, ih;
      logic [18:0] s;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // default frame: pixel extremes at the start of the first row, then a new frame start
      send_pixel(24'hFFFFFF, 1'b1);
      send_pixel(24'h000000, 1'b0);
      send_pixel(24'hFF0000, 1'b0);
      send_pixel(24'h00FF00, 1'b0);
      send_pixel(24'h0000FF, 1'b0);
      send_pixel(24'h808080, 1'b1);

      // single-pixel frames, full strength, zero inverse sizes
      setup_frame(13'd1, 13'd1, 17'd0, 17'd0, 19'sd131072);
      repeat (3) send_pixel(24'hFFFFFF, 1'b0);
      // out-of-range sizes, largest inverse sizes and extreme strengths
      setup_frame(13'd0, 13'd8191, 17'h1FFFF, 17'h1FFFF, 19'h40000);
      repeat (3) send_pixel(24'hA5A5A5, 1'b0);
      setup_frame(13'd4096, 13'd4096, 17'd16, 17'd16, 19'h3FFFF);
      repeat (3) send_pixel(24'h5A5A5A, 1'b0);
      setup_frame(13'd3, 13'd2, 17'd21845, 17'd32768, -19'sd131072);
      for (k = 0; k < 7; k++) send_pixel(24'hFFFFFF, k == 0);
      // shrink mid-frame: counters already at the new last position
      setup_frame(13'd2, 13'd1, 17'd32768, 17'd65536, 19'd0);
      send_pixel(24'h123456, 1'b0);
      send_pixel(24'hFEDCBA, 1'b0);

      for (phase = 0; pixels_sent < 950; phase++) begin
         case (phase % 4)
            0: begin w = $urandom_range(1, 8); h = $urandom_range(1, 8); end
            1: begin w = $urandom_range(1, 24); h = $urandom_range(1, 6); end
            2: begin w = $urandom_range(0, 8191); h = $urandom_range(0, 8191); end
            default: begin w = $urandom_range(1, 16); h = $urandom_range(1, 16); end
         endcase
         if ($urandom_range(0, 3) == 0) begin
            iw = 17'($urandom_range(0, 17'h1FFFF));
            ih = 17'($urandom_range(0, 17'h1FFFF));
         end else begin
            iw = 17'((65536 + (w > 0 ? w : 1) / 2) / (w > 0 ? w : 1));
            ih = 17'((65536 + (h > 0 ? h : 1) / 2) / (h > 0 ? h : 1));
         end
         s = ($urandom_range(0, 2) == 0) ? 19'($urandom) :
             19'(int'($urandom_range(0, 262144)) - 131072);
         send_gap_max  = (phase % 5 == 1) ? 0 : 15;
         drain_gap_max = (phase % 5 == 2) ? 0 : 15;
         setup_frame(13'(w), 13'(h), iw, ih, s);
         for (n = 0; n < 80 && pixels_sent < 950; ) begin
            if ($urandom_range(0, 9) == 0) begin
               send_pixel(24'($urandom), 1'($urandom));
               n++;
            end else begin
               for (k = 0; k < w * h && k < 60; k++)
                  send_pixel(24'($urandom), k == 0);
               n += (k > 0) ? k : 1;
            end
         end
      end

      drain_idle();
      $display("Sent %0d pixels over %0d register settings; %0d frame ends seen.",
         pixels_sent, phase + 6, frames_done);
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin
      #20ms;
      $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/rvpf_pkg.sv
hw/rtl/rvpf_front.sv
hw/rtl/rvpf_queue.sv
hw/rtl/rvpf_back.sv
hw/rtl/radial_vignette_pixel_filter.sv
verif/rvpf_checker.sv
verif/tb_radial_vignette_pixel_filter.sv
